FILE: hdl/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // opcodes, also used as the active command code (OP_TICK doubles as idle)
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_STOP  = 3'd2;
  localparam logic [2:0] OP_WRITE = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;
  localparam logic [2:0] OP_SACK  = 3'd5;
  localparam logic [2:0] OP_RACK  = 3'd6;
  // spare opcode: behaves as a plain tick
  localparam logic [2:0] OP_SPARE = 3'd7;

  localparam logic [15:0] SETTLE_RESET = 16'd10;

  // configuration register indexes
  localparam logic REG_SETTLE = 1'b0;

  // one queued word: command already classified by the front end
  typedef struct packed {
    logic [2:0] cmd;          // OP_TICK when the opcode starts nothing
    logic [7:0] data_byte;
    logic       ack_to_send;
    logic       sda_in;
  } q_entry_t;

  // push request from front end to queue
  typedef struct packed {
    logic     push;
    q_entry_t entry;
  } q_push_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

  typedef struct packed {
    logic       rejected;
    logic       ack_received;
    logic [7:0] read_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } result_t;

  // number of steps (pin writes and SDA samples) per command
  function automatic logic [4:0] seq_len(input logic [2:0] cmd);
    logic [4:0] len;
    unique case (cmd)
      OP_START: len = 5'd4;
      OP_STOP:  len = 5'd3;
      OP_WRITE: len = 5'd24;
      OP_READ:  len = 5'd25;
      OP_SACK:  len = 5'd3;
      OP_RACK:  len = 5'd4;
      default:  len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

FILE: hdl/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// Input side: accepts words and classifies the opcode into a command code.
// ----------------------------------------------------------------------------
module i2cm_front (
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [2:0]        in_tuser,
  input  logic [15:0]       in_tdata,
  input  logic              q_full,
  output i2cm_pkg::q_push_t q_push
);

  logic is_cmd;

  // opcode seven and zero start nothing
  assign is_cmd    = (in_tuser != i2cm_pkg::OP_TICK) && (in_tuser != i2cm_pkg::OP_SPARE);
  assign in_tready = !q_full;

  always_comb begin
    q_push.push              = in_tvalid && !q_full;
    q_push.entry.cmd         = is_cmd ? in_tuser : i2cm_pkg::OP_TICK;
    q_push.entry.data_byte   = in_tdata[7:0];
    q_push.entry.ack_to_send = in_tdata[8];
    q_push.entry.sda_in      = in_tdata[9];
  end

endmodule

FILE: hdl/i2cm_queue.sv
// ----------------------------------------------------------------------------
// i2cm_queue
// Short register FIFO between front end and back end.
// ----------------------------------------------------------------------------
module i2cm_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  i2cm_pkg::q_push_t q_push,
  input  logic              pop,
  output logic              full,
  output i2cm_pkg::q_head_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  i2cm_pkg::q_entry_t mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full       = (cnt_r == FULL_CNT);
  assign do_push    = q_push.push && !full;
  assign do_pop     = pop && (cnt_r != '0);
  assign head.valid = (cnt_r != '0);
  assign head.entry = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
    if (do_pop)  rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= q_push.entry;
  end

endmodule

FILE: hdl/i2cm_back.sv
// ----------------------------------------------------------------------------
// i2cm_back
// Bit sequencer: runs one tick per word and registers the result word.
// ----------------------------------------------------------------------------
module i2cm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [15:0]       settle_ticks,
  input  i2cm_pkg::q_head_t head,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output i2cm_pkg::result_t out_res
);

  logic [2:0]  act_r, act_nxt;
  logic [4:0]  step_r, step_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] settle_r, settle_nxt;
  logic        scl_r, scl_nxt, sda_r, sda_nxt, ack_r, ack_nxt;
  logic [7:0]  last_read_r, last_read_nxt;
  logic        rej, done;
  logic [4:0]  len;
  logic        out_valid_r, out_valid_nxt;
  i2cm_pkg::result_t res_r, res_nxt;

  assign pop        = head.valid && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_res    = res_r;

  always_comb begin
    act_nxt       = act_r;
    step_nxt      = step_r;
    phase_nxt     = phase_r;
    shift_nxt     = shift_r;
    settle_nxt    = settle_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    ack_nxt       = ack_r;
    last_read_nxt = last_read_r;
    rej           = 1'b0;
    done          = 1'b0;
    len           = '0;

    if (head.entry.cmd != i2cm_pkg::OP_TICK) begin
      if (act_r != i2cm_pkg::OP_TICK) begin
        rej = 1'b1;
      end else begin
        act_nxt    = head.entry.cmd;
        step_nxt   = '0;
        phase_nxt  = '0;
        settle_nxt = '0;
        if (head.entry.cmd == i2cm_pkg::OP_WRITE) shift_nxt = head.entry.data_byte;
        else if (head.entry.cmd == i2cm_pkg::OP_SACK) shift_nxt = {7'd0, head.entry.ack_to_send};
        else shift_nxt = '0;
      end
    end

    if (act_nxt != i2cm_pkg::OP_TICK) begin
      len = i2cm_pkg::seq_len(act_nxt);
      if (settle_nxt != '0) begin
        settle_nxt = settle_nxt - 1'b1;
      end else if (step_nxt < len) begin
        unique case (act_nxt)
          i2cm_pkg::OP_START: begin
            priority if (step_nxt == 5'd0) sda_nxt = 1'b1;
            else if (step_nxt == 5'd1) scl_nxt = 1'b1;
            else if (step_nxt == 5'd2) sda_nxt = 1'b0;
            else scl_nxt = 1'b0;
          end
          i2cm_pkg::OP_STOP: begin
            priority if (step_nxt == 5'd0) sda_nxt = 1'b0;
            else if (step_nxt == 5'd1) scl_nxt = 1'b1;
            else sda_nxt = 1'b1;
          end
          i2cm_pkg::OP_WRITE: begin
            priority if (phase_nxt == 2'd0) begin
              sda_nxt   = shift_nxt[7];
              shift_nxt = {shift_nxt[6:0], 1'b0};
            end else if (phase_nxt == 2'd1) begin
              scl_nxt = 1'b1;
            end else begin
              scl_nxt = 1'b0;
            end
            phase_nxt = (phase_nxt == 2'd2) ? 2'd0 : phase_nxt + 2'd1;
          end
          i2cm_pkg::OP_READ: begin
            if (step_nxt == 5'd0) begin
              sda_nxt = 1'b1;
            end else begin
              priority if (phase_nxt == 2'd0) scl_nxt = 1'b1;
              else if (phase_nxt == 2'd1) shift_nxt = {shift_nxt[6:0], head.entry.sda_in};
              else scl_nxt = 1'b0;
              phase_nxt = (phase_nxt == 2'd2) ? 2'd0 : phase_nxt + 2'd1;
            end
          end
          i2cm_pkg::OP_SACK: begin
            priority if (step_nxt == 5'd0) sda_nxt = shift_nxt[0];
            else if (step_nxt == 5'd1) scl_nxt = 1'b1;
            else scl_nxt = 1'b0;
          end
          i2cm_pkg::OP_RACK: begin
            priority if (step_nxt == 5'd0) sda_nxt = 1'b1;
            else if (step_nxt == 5'd1) scl_nxt = 1'b1;
            else if (step_nxt == 5'd2) ack_nxt = head.entry.sda_in;
            else scl_nxt = 1'b0;
          end
          default: ;
        endcase
        step_nxt   = step_nxt + 5'd1;
        settle_nxt = settle_ticks;
      end
      if ((step_nxt >= len) && (settle_nxt == '0)) begin
        if (act_nxt == i2cm_pkg::OP_READ) last_read_nxt = shift_nxt;
        done     = 1'b1;
        act_nxt  = i2cm_pkg::OP_TICK;
        step_nxt = '0;
      end
    end

    res_nxt.scl_out      = scl_nxt;
    res_nxt.sda_out      = sda_nxt;
    res_nxt.busy_res     = (act_nxt != i2cm_pkg::OP_TICK);
    res_nxt.done_res     = done;
    res_nxt.read_byte    = last_read_nxt;
    res_nxt.ack_received = ack_nxt;
    res_nxt.rejected     = rej;

    out_valid_nxt = pop ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= i2cm_pkg::OP_TICK;
      step_r      <= '0;
      phase_r     <= '0;
      shift_r     <= '0;
      settle_r    <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      ack_r       <= 1'b1;
      last_read_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        act_r       <= act_nxt;
        step_r      <= step_nxt;
        phase_r     <= phase_nxt;
        shift_r     <= shift_nxt;
        settle_r    <= settle_nxt;
        scl_r       <= scl_nxt;
        sda_r       <= sda_nxt;
        ack_r       <= ack_nxt;
        last_read_r <= last_read_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) res_r <= res_nxt;
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (act_r == i2cm_pkg::OP_TICK) |-> (step_r == '0) && (settle_r == '0))
    else $error("idle sequencer holds a stale step or settle count");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= 5'd25)
    else $error("step index beyond longest action list");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.done_res) |-> !res_r.busy_res)
    else $error("done word still reports busy");

  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (head.entry.cmd != i2cm_pkg::OP_TICK) && (act_r != i2cm_pkg::OP_TICK))
      |=> (out_valid_r && res_r.rejected))
    else $error("command during busy not flagged as rejected");

endmodule

FILE: hdl/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Path: an input word accepted on in_ is written into the queue, then popped
// into the registered result word, which drives out_.
// Throughput: one word per cycle while out_ accepts; one tick per popped word.
// Result register and the queue let either side stall on its own.
// Reset: synchronous, active low; lines released, settle_ticks back to 10,
// queue and output register emptied.
// ----------------------------------------------------------------------------
// Open-drain I2C bit sequencer. Every input word is one tick, optionally
// carrying a command (start, stop, write byte, read byte, send ack, receive
// ack). Each pin write or SDA sample is followed by settle_ticks idle ticks.
// A command that arrives while one is running is flagged and dropped.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [2:0]  in_tuser,     // [2:0] opcode
  input  logic [15:0] in_tdata,     // [7:0] data_byte, [8] ack_to_send, [9] sda_in
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // [0] scl_out, [1] sda_out, [2] busy_res,
                                    // [3] done_res, [11:4] read_byte,
                                    // [12] ack_received, [13] rejected
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  i2cm_pkg::q_push_t q_push;
  i2cm_pkg::q_head_t q_head;
  i2cm_pkg::result_t res;
  logic              q_full;
  logic              q_pop;
  logic [15:0]       settle_ticks_r, settle_ticks_nxt;
  logic              cfg_wr;

  // APB: always ready, write lands on the access cycle
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    settle_ticks_nxt = settle_ticks_r;
    if (cfg_wr && (cfg_paddr[2] == i2cm_pkg::REG_SETTLE)) settle_ticks_nxt = cfg_pwdata[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_ticks_r <= i2cm_pkg::SETTLE_RESET;
    end else begin
      settle_ticks_r <= settle_ticks_nxt;
    end
  end

  // read back; addresses with paddr[2] clear return the single register, the rest zero
  assign cfg_prdata = (cfg_paddr[2] == i2cm_pkg::REG_SETTLE) ? {16'd0, settle_ticks_r} : 32'd0;

  // front end: accept and classify
  i2cm_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push)
  );

  // decoupling queue
  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (q_pop),
    .full   (q_full),
    .head   (q_head)
  );

  // back end: advance the bit sequence, hold the result word
  i2cm_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .settle_ticks (settle_ticks_r),
    .head         (q_head),
    .pop          (q_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_res      (res)
  );

  assign out_tdata = {2'b00, res.rejected, res.ack_received, res.read_byte,
                      res.done_res, res.busy_res, res.sda_out, res.scl_out};

endmodule
